@@ design/gep_pkg.sv @@
// shared types and constants for the genotype emission product block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gep_pkg;

  localparam int MAX_ALLELES = 256;
  localparam int MAX_SAMPLES = 1024;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] FP_ONE     = 64'h3FF0000000000000;
  localparam logic [63:0] FP_HALF    = 64'h3FE0000000000000;
  localparam logic [63:0] FP_THIRD   = 64'h3FD5555555555555;
  localparam logic [63:0] FP_DEF_NAN = 64'hFFF8000000000000;
  localparam logic [63:0] FP_QBIT    = 64'h0008000000000000;

  localparam logic [1:0] CFG_ALLELE_TOTAL = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_SLOT  = 2'd1;

  // factor recipe of one word
  typedef enum logic [1:0] {K_NONE, K_DIRECT, K_HALF, K_THIRD} kind_t;

  typedef enum logic {FP_ADD, FP_MUL} fp_op_t;

  typedef enum logic [1:0] {STEP_SUM0, STEP_SUM1, STEP_SCALE, STEP_PROD} step_t;

  typedef struct packed {
    logic   start;
    fp_op_t op;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fp_rsp_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic        err;
    logic        last;
    logic        newvar;
    logic [7:0]  a1;
    logic [7:0]  a2;
  } item_t;

  typedef enum logic [3:0] {
    F_IDLE, F_CLASS, F_PRENORM, F_MUL, F_ACC, F_MPACK,
    F_ALIGN, F_SUM, F_NORM, F_ROUND, F_DONE
  } fpu_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SLOT, B_BASE, B_ISSUE, B_WAIT, B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

@@ design/gep_fpu.sv @@
// binary64 add / multiply unit, round to nearest even, sequenced over cycles
// depends on gep_pkg
`timescale 1ns / 1ps
`default_nettype none

module gep_fpu import gep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fp_req_t     req,
  input  logic [63:0] req_a,
  input  logic [63:0] req_b,
  output fp_rsp_t     rsp
);

  fpu_state_t state_r, state_nxt;

  logic [63:0]        a_r, b_r, res_r;
  fp_op_t             op_r;
  logic               sa_r, sb_r, s_r, sub_r;
  logic signed [12:0] ea_r, eb_r, e_r;
  logic [52:0]        ma_r, mb_r;
  logic [105:0]       acc_r;
  logic [53:0]        pp_r;
  logic [1:0]         ppi_r;
  logic [56:0]        m_r, hi_r, lo_r;

  // operand classification
  logic [10:0] expa, expb;
  logic [51:0] fra, frb;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic signed [12:0] ua_e, ub_e;
  logic [52:0] ua_m, ub_m;
  logic sp_hit;
  logic [63:0] sp_res;

  always_comb begin
    expa = a_r[62:52];
    expb = b_r[62:52];
    fra  = a_r[51:0];
    frb  = b_r[51:0];
    nan_a  = (&expa) && (|fra);
    nan_b  = (&expb) && (|frb);
    inf_a  = (&expa) && !(|fra);
    inf_b  = (&expb) && !(|frb);
    zero_a = !(|expa) && !(|fra);
    zero_b = !(|expb) && !(|frb);
    ua_e = (expa == 11'd0) ? 13'sd1 : $signed({2'b00, expa});
    ub_e = (expb == 11'd0) ? 13'sd1 : $signed({2'b00, expb});
    ua_m = {|expa, fra};
    ub_m = {|expb, frb};
    sp_hit = 1'b1;
    sp_res = 64'd0;
    if (nan_a) begin
      sp_res = a_r | FP_QBIT;
    end else if (nan_b) begin
      sp_res = b_r | FP_QBIT;
    end else if (op_r == FP_MUL) begin
      if ((inf_a && zero_b) || (zero_a && inf_b)) begin
        sp_res = FP_DEF_NAN;
      end else if (inf_a || inf_b) begin
        sp_res = {a_r[63] ^ b_r[63], 11'h7FF, 52'd0};
      end else if (zero_a || zero_b) begin
        sp_res = {a_r[63] ^ b_r[63], 63'd0};
      end else begin
        sp_hit = 1'b0;
      end
    end else begin
      if (inf_a && inf_b && (a_r[63] != b_r[63])) begin
        sp_res = FP_DEF_NAN;
      end else if (inf_a) begin
        sp_res = a_r;
      end else if (inf_b) begin
        sp_res = b_r;
      end else if (zero_a && zero_b) begin
        sp_res = {a_r[63] & b_r[63], 63'd0};
      end else begin
        sp_hit = 1'b0;
      end
    end
  end

  // partial products of the 53x53 significand multiply
  logic [26:0]  opx, opy;
  logic [53:0]  pp;
  logic [6:0]   shamt;
  logic [105:0] addend;

  always_comb begin
    case (ppi_r)
      2'd0: begin
        opx = {1'b0, ma_r[25:0]};
        opy = {1'b0, mb_r[25:0]};
        shamt = 7'd0;
      end
      2'd1: begin
        opx = {1'b0, ma_r[25:0]};
        opy = mb_r[52:26];
        shamt = 7'd26;
      end
      2'd2: begin
        opx = ma_r[52:26];
        opy = {1'b0, mb_r[25:0]};
        shamt = 7'd26;
      end
      default: begin
        opx = ma_r[52:26];
        opy = mb_r[52:26];
        shamt = 7'd52;
      end
    endcase
    pp = opx * opy;
    addend = {52'd0, pp_r} << shamt;
  end

  // alignment of the smaller addend, sticky jammed into the lowest bit
  logic        a_big;
  logic [11:0] d;
  logic [52:0] m_lo;
  logic [56:0] lo_ext, lo_sh, lo_mask;

  always_comb begin
    a_big = {ea_r[11:0], ma_r} >= {eb_r[11:0], mb_r};
    d     = a_big ? (ea_r[11:0] - eb_r[11:0]) : (eb_r[11:0] - ea_r[11:0]);
    m_lo  = a_big ? mb_r : ma_r;
    lo_ext = {1'b0, m_lo, 3'b000};
    lo_mask = '0;
    if (d >= 12'd57) begin
      lo_sh = {56'd0, |m_lo};
    end else begin
      lo_mask = (57'd1 << d[5:0]) - 57'd1;
      lo_sh = lo_ext >> d[5:0];
      lo_sh[0] = lo_sh[0] | (|(lo_ext & lo_mask));
    end
  end

  logic [56:0] sum;
  assign sum = sub_r ? (hi_r - lo_r) : (hi_r + lo_r);

  // one normalization step a cycle
  logic [56:0]        m_n;
  logic signed [12:0] e_n;
  logic               norm_done;

  always_comb begin
    m_n = m_r;
    e_n = e_r;
    norm_done = 1'b0;
    if (e_r < -13'sd60) begin
      // far below the smallest subnormal: only stickiness survives
      m_n = {56'd0, |m_r};
      e_n = 13'sd1;
    end else if (m_r[56] || (e_r < 13'sd1)) begin
      m_n = {1'b0, m_r[56:2], m_r[1] | m_r[0]};
      e_n = e_r + 13'sd1;
    end else if (!m_r[55] && (e_r > 13'sd1)) begin
      m_n = {m_r[55:0], 1'b0};
      e_n = e_r - 13'sd1;
    end else begin
      norm_done = 1'b1;
    end
  end

  logic               up;
  logic [53:0]        sig;
  logic signed [12:0] ef;
  logic [51:0]        fr;
  logic [63:0]        rnd_res;

  always_comb begin
    up  = m_r[2] & (m_r[3] | m_r[1] | m_r[0]);
    sig = {1'b0, m_r[55:3]} + {53'd0, up};
    if (sig[53]) begin
      ef = e_r + 13'sd1;
      fr = 52'd0;
    end else if (sig[52]) begin
      ef = e_r;
      fr = sig[51:0];
    end else begin
      ef = 13'sd0;
      fr = sig[51:0];
    end
    if (ef >= 13'sd2047) begin
      rnd_res = {s_r, 11'h7FF, 52'd0};
    end else begin
      rnd_res = {s_r, ef[10:0], fr};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:    if (req.start) state_nxt = F_CLASS;
      F_CLASS: begin
        if (sp_hit) state_nxt = F_DONE;
        else if (op_r == FP_MUL) state_nxt = F_PRENORM;
        else state_nxt = F_ALIGN;
      end
      F_PRENORM: if (ma_r[52] && mb_r[52]) state_nxt = F_MUL;
      F_MUL:     state_nxt = F_ACC;
      F_ACC:     state_nxt = (ppi_r == 2'd3) ? F_MPACK : F_MUL;
      F_MPACK:   state_nxt = F_NORM;
      F_ALIGN:   state_nxt = F_SUM;
      F_SUM:     state_nxt = (sum == 57'd0) ? F_DONE : F_NORM;
      F_NORM:    if (norm_done) state_nxt = F_ROUND;
      F_ROUND:   state_nxt = F_DONE;
      F_DONE:    state_nxt = F_IDLE;
      default:   state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == F_DONE);
    rsp.res  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (req.start) begin
          a_r  <= req_a;
          b_r  <= req_b;
          op_r <= req.op;
        end
      end
      F_CLASS: begin
        res_r <= sp_res;
        ea_r  <= ua_e;
        eb_r  <= ub_e;
        ma_r  <= ua_m;
        mb_r  <= ub_m;
        sa_r  <= a_r[63];
        sb_r  <= b_r[63];
        acc_r <= '0;
        ppi_r <= 2'd0;
      end
      F_PRENORM: begin
        // subnormal significands are brought up to the hidden bit first
        if (!ma_r[52]) begin
          ma_r <= {ma_r[51:0], 1'b0};
          ea_r <= ea_r - 13'sd1;
        end else if (!mb_r[52]) begin
          mb_r <= {mb_r[51:0], 1'b0};
          eb_r <= eb_r - 13'sd1;
        end
      end
      F_MUL: pp_r <= pp;
      F_ACC: begin
        acc_r <= acc_r + addend;
        ppi_r <= ppi_r + 2'd1;
      end
      F_MPACK: begin
        m_r <= {acc_r[105:50], acc_r[49] | (|acc_r[48:0])};
        e_r <= ea_r + eb_r - 13'sd1023;
        s_r <= sa_r ^ sb_r;
      end
      F_ALIGN: begin
        hi_r  <= {1'b0, (a_big ? ma_r : mb_r), 3'b000};
        lo_r  <= lo_sh;
        e_r   <= a_big ? ea_r : eb_r;
        s_r   <= a_big ? sa_r : sb_r;
        sub_r <= sa_r ^ sb_r;
      end
      F_SUM: begin
        m_r   <= sum;
        res_r <= 64'd0;
      end
      F_NORM: begin
        m_r <= m_n;
        e_r <= e_n;
      end
      F_ROUND: res_r <= rnd_res;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/gep_back.sv @@
// back end: runs the factor recipe of each queued word through the fp unit,
// keeps the running product and flags, forms the result word; uses gep_pkg, gep_fpu
`timescale 1ns / 1ps
`default_nettype none

module gep_back import gep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [8:0]  allele_total,
  input  logic [9:0]  sample_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_emission_value,
  output logic [25:0] out_pair_slot,
  output logic        out_is_positive,
  output logic        out_any_positive,
  output logic        out_count_error
);

  back_state_t state_r, state_nxt;

  item_t       item_r;
  step_t       step_r;
  logic [63:0] t_r, prod_r;
  logic        pos_seen_r, err_seen_r;
  logic [15:0] size_r;
  logic [25:0] tri_r, slot_r;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [25:0] out_slot_r;
  logic        out_pos_r, out_any_r, out_err_r;

  fp_req_t     req;
  fp_rsp_t     rsp;
  logic [63:0] op_a, op_b;

  gep_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .req_a (op_a),
    .req_b (op_b),
    .rsp   (rsp)
  );

  logic out_free, emit_load, pos, any;
  assign out_free = !out_valid_r || !out_stall;
  assign pos = !prod_r[63] && (|prod_r[62:0]) && !((&prod_r[62:52]) && (|prod_r[51:0]));
  assign any = pos | pos_seen_r;

  // triangle slot; ids past allele_total wrap as the unsigned formula does
  logic [7:0]  amin, amax;
  logic [9:0]  n10;
  logic [19:0] nn;
  logic [26:0] k27, ak27;
  logic [25:0] slot_sum;

  always_comb begin
    amin = (item_r.a1 < item_r.a2) ? item_r.a1 : item_r.a2;
    amax = (item_r.a1 < item_r.a2) ? item_r.a2 : item_r.a1;
    n10  = {1'b0, allele_total};
    nn   = n10 * (n10 + 10'd1);
    k27  = {17'd0, allele_total, 1'b1} - {19'd0, amin};
    ak27 = {19'd0, amin} * k27;
    slot_sum = ({16'd0, sample_slot} * {10'd0, size_r}) + tri_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_SLOT;
      B_SLOT:  state_nxt = B_BASE;
      B_BASE: begin
        if (item_r.kind != K_NONE) state_nxt = B_ISSUE;
        else if (item_r.last) state_nxt = B_EMIT;
        else state_nxt = B_IDLE;
      end
      B_ISSUE: state_nxt = B_WAIT;
      B_WAIT: begin
        if (rsp.done) begin
          if (step_r != STEP_PROD) state_nxt = B_ISSUE;
          else if (item_r.last) state_nxt = B_EMIT;
          else state_nxt = B_IDLE;
        end
      end
      B_EMIT:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    emit_load = (state_r == B_EMIT) && out_free;
    req.start = (state_r == B_ISSUE);
    unique case (step_r)
      STEP_SUM0: begin
        req.op = FP_ADD;
        op_a = item_r.x;
        op_b = item_r.y;
      end
      STEP_SUM1: begin
        req.op = FP_ADD;
        op_a = t_r;
        op_b = item_r.z;
      end
      STEP_SCALE: begin
        req.op = FP_MUL;
        op_a = t_r;
        op_b = (item_r.kind == K_THIRD) ? FP_THIRD : FP_HALF;
      end
      default: begin
        req.op = FP_MUL;
        op_a = prod_r;
        op_b = t_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      prod_r      <= FP_ONE;
      pos_seen_r  <= 1'b0;
      err_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (q_item.newvar) pos_seen_r <= 1'b0;
        err_seen_r <= err_seen_r | q_item.err;
      end
      if ((state_r == B_WAIT) && rsp.done && (step_r == STEP_PROD)) prod_r <= rsp.res;
      if (emit_load) begin
        prod_r      <= FP_ONE;
        err_seen_r  <= 1'b0;
        pos_seen_r  <= any;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      t_r    <= q_item.x;
      step_r <= (q_item.kind == K_DIRECT) ? STEP_PROD : STEP_SUM0;
    end
    if (state_r == B_SLOT) begin
      size_r <= nn[16:1];
      tri_r  <= ak27[26:1] + {18'd0, amax - amin};
    end
    if (state_r == B_BASE) slot_r <= slot_sum;
    if ((state_r == B_WAIT) && rsp.done) begin
      if (step_r != STEP_PROD) t_r <= rsp.res;
      case (step_r)
        STEP_SUM0: step_r <= (item_r.kind == K_THIRD) ? STEP_SUM1 : STEP_SCALE;
        STEP_SUM1: step_r <= STEP_SCALE;
        default:   step_r <= STEP_PROD;
      endcase
    end
    if (emit_load) begin
      out_value_r <= prod_r;
      out_slot_r  <= slot_r;
      out_pos_r   <= pos;
      out_any_r   <= any;
      out_err_r   <= err_seen_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_emission_value = out_value_r;
  assign out_pair_slot      = out_slot_r;
  assign out_is_positive    = out_pos_r;
  assign out_any_positive   = out_any_r;
  assign out_count_error    = out_err_r;

endmodule

`default_nettype wire

@@ design/gep_queue.sv @@
// short word queue between front and back end
// depends on gep_pkg
`timescale 1ns / 1ps
`default_nettype none

module gep_queue import gep_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slots_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop) rd_r <= (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_r] <= push_item;
  end

endmodule

`default_nettype wire

@@ design/gep_front.sv @@
// front end: accepts k-mer words and sorts each into a factor recipe
// depends on gep_pkg
`timescale 1ns / 1ps
`default_nettype none

module gep_front import gep_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_first_allele,
  input  logic [7:0]  in_second_allele,
  input  logic        in_first_undefined,
  input  logic        in_second_undefined,
  input  logic        in_first_present,
  input  logic        in_second_present,
  input  logic [63:0] in_prob_copy_zero,
  input  logic [63:0] in_prob_copy_one,
  input  logic [63:0] in_prob_copy_two,
  input  logic        in_has_kmer,
  input  logic        in_last_kmer,
  input  logic        in_new_variant,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic [1:0]  c;
  logic [63:0] pc, pc1;

  always_comb begin
    c = {1'b0, in_first_present} + {1'b0, in_second_present};
    case (c)
      2'd0: begin
        pc  = in_prob_copy_zero;
        pc1 = in_prob_copy_one;
      end
      2'd1: begin
        pc  = in_prob_copy_one;
        pc1 = in_prob_copy_two;
      end
      default: begin
        // no copy-three probability: plus zero stands in
        pc  = in_prob_copy_two;
        pc1 = 64'd0;
      end
    endcase
  end

  always_comb begin
    q_item.x      = pc;
    q_item.y      = pc1;
    q_item.z      = in_prob_copy_two;
    q_item.err    = 1'b0;
    q_item.last   = in_last_kmer;
    q_item.newvar = in_new_variant;
    q_item.a1     = in_first_allele;
    q_item.a2     = in_second_allele;
    if (!in_has_kmer) begin
      q_item.kind = K_NONE;
    end else if (in_first_undefined && in_second_undefined) begin
      q_item.kind = K_THIRD;
      q_item.x    = in_prob_copy_zero;
      q_item.y    = in_prob_copy_one;
    end else if (in_first_undefined || in_second_undefined) begin
      q_item.kind = K_HALF;
      q_item.err  = (c == 2'd2);
    end else begin
      q_item.kind = K_DIRECT;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

@@ design/genotype_emission_product_core.sv @@
// emission product core: a word is taken whenever the 4-deep queue has room;
// the back end works one word at a time: slot and base steps, then per fp op an issue
// and a wait; a multiply forms 4 partial products of 27x27 bits, each multiplied and
// accumulated, after shifting a subnormal operand up one bit per step; an add aligns,
// sums and normalizes; a plain factor is one multiply, half an add and two multiplies,
// third two adds and two multiplies; synchronous reset, product returns to 1.0
`timescale 1ns / 1ps
`default_nettype none

module genotype_emission_product_core import gep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_first_allele,
  input  logic [7:0]  in_second_allele,
  input  logic        in_first_undefined,
  input  logic        in_second_undefined,
  input  logic        in_first_present,
  input  logic        in_second_present,
  input  logic [63:0] in_prob_copy_zero,
  input  logic [63:0] in_prob_copy_one,
  input  logic [63:0] in_prob_copy_two,
  input  logic        in_has_kmer,
  input  logic        in_last_kmer,
  input  logic        in_new_variant,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_emission_value,
  output logic [25:0] out_pair_slot,
  output logic        out_is_positive,
  output logic        out_any_positive,
  output logic        out_count_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [8:0] allele_total_r, allele_nxt;
  logic [9:0] sample_slot_r, sample_nxt;

  always_comb begin
    allele_nxt = cfg_data[8:0];
    if (allele_nxt == 9'd0) allele_nxt = 9'd1;
    else if (int'(allele_nxt) > MAX_ALLELES) allele_nxt = 9'(MAX_ALLELES);
    sample_nxt = cfg_data;
    if (int'(sample_nxt) > MAX_SAMPLES - 1) sample_nxt = 10'(MAX_SAMPLES - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allele_total_r <= 9'd1;
      sample_slot_r  <= 10'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALLELE_TOTAL) allele_total_r <= allele_nxt;
      if (cfg_index == CFG_SAMPLE_SLOT) sample_slot_r <= sample_nxt;
    end
  end

  logic  q_full, q_push, q_pop, q_empty;
  item_t push_item, pop_item;

  gep_front u_front (
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_allele     (in_first_allele),
    .in_second_allele    (in_second_allele),
    .in_first_undefined  (in_first_undefined),
    .in_second_undefined (in_second_undefined),
    .in_first_present    (in_first_present),
    .in_second_present   (in_second_present),
    .in_prob_copy_zero   (in_prob_copy_zero),
    .in_prob_copy_one    (in_prob_copy_one),
    .in_prob_copy_two    (in_prob_copy_two),
    .in_has_kmer         (in_has_kmer),
    .in_last_kmer        (in_last_kmer),
    .in_new_variant      (in_new_variant),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_item              (push_item)
  );

  gep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  gep_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .q_pop              (q_pop),
    .allele_total       (allele_total_r),
    .sample_slot        (sample_slot_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_emission_value (out_emission_value),
    .out_pair_slot      (out_pair_slot),
    .out_is_positive    (out_is_positive),
    .out_any_positive   (out_any_positive),
    .out_count_error    (out_count_error)
  );

endmodule

`default_nettype wire
